@@ src/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg - shared constants for the stereo chorus delay
// Register indexes, register widths and reset values, default sizes.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int DEF_DELAY_DEPTH  = 2048;
  localparam int DEF_SINE_ENTRIES = 256;
  localparam int DEF_SAMPLE_BITS  = 24;

  localparam int LFO_BITS     = 24;
  localparam int PHASE_STEP_W = 23;
  localparam int DELAY_REG_W  = 19;
  localparam int FB_W         = 16;
  localparam int MIX_W        = 17;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 3'd0,
    REG_BASE_DELAY = 3'd1,
    REG_MOD_SPAN   = 3'd2,
    REG_FEEDBACK   = 3'd3,
    REG_WET_MIX    = 3'd4
  } reg_idx_t;

  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST = 23'd350;
  localparam logic [DELAY_REG_W-1:0]  BASE_DELAY_RST = 19'd245760;
  localparam logic [DELAY_REG_W-1:0]  MOD_SPAN_RST   = 19'd0;
  localparam logic [FB_W-1:0]         FEEDBACK_RST   = 16'd0;
  localparam logic [MIX_W-1:0]        WET_MIX_RST    = 17'd32768;

  localparam logic [FB_W-1:0]  FB_MAX  = 16'd62259;
  localparam logic [MIX_W-1:0] MIX_MAX = 17'd65536;

  // sine table generation, Q2.30
  localparam longint PI_Q30  = 64'd3373259426;
  localparam longint ONE_Q30 = 64'd1073741824;

endpackage

@@ src/stereo_chorus_delay.sv @@
// ----------------------------------------------------------------------------
// stereo_chorus_delay - modulated delay chorus with feedback
// Sine LFO sweeps an interpolated read tap on two delay rings.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one stereo frame per item (left in the low bits).
//   m_axis returns one stereo frame per item, in order.
//   cfg_we/cfg_index/cfg_wdata write the control registers; write only while
//   no item is in flight.
// Sequencing:
//   A taken item passes through the states SPAN, ADDR, READ, INTERP, MULT
//   and WRITE; its result is registered on m_axis in WRITE. The sequencer
//   handles one item at a time: sine lookup and span multiply, tap address,
//   ring read, interpolation, gain multiplies and ring write-back.
// Reset:
//   Registers return to their defaults, the LFO phase and write pointer clear.
//   Ring entries not yet written since reset read as zero (tracked by the
//   write pointer and a wrap flag), so no clearing pass is needed.
// Stall:
//   A finished item waits in the output register; the next item is accepted
//   meanwhile and its write-back waits until the output register is free.
// ----------------------------------------------------------------------------
module stereo_chorus_delay #(
  parameter int DELAY_DEPTH  = scd_pkg::DEF_DELAY_DEPTH,
  parameter int SINE_ENTRIES = scd_pkg::DEF_SINE_ENTRIES,
  parameter int SAMPLE_BITS  = scd_pkg::DEF_SAMPLE_BITS,
  localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,  // left_in, right_in, zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TDATA_W-1:0]              m_axis_tdata,  // left_out, right_out, zero pad
  input  logic                            cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import scd_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int IXW  = $clog2(SINE_ENTRIES);
  localparam int PPW  = LFO_BITS + $clog2(SINE_ENTRIES + 1);
  localparam int DW   = DELAY_REG_W + 2;
  localparam int DMAX = (DELAY_DEPTH - 2) * 256;
  localparam int ISW  = SB + 11;
  localparam int FPW  = SB + 17;
  localparam int OPW  = SB + 18;
  localparam int OW   = SB + 19;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SPAN, ST_ADDR, ST_READ, ST_INTERP, ST_MULT, ST_WRITE
  } state_t;

  // ---------------------------------------------------------------- sine rom
  function automatic logic signed [15:0] sine_q15(input int unsigned k);
    longint          x;
    longint          x2;
    longint          term;
    longint          sum;
    longint unsigned xu;
    int unsigned     m;
    logic            neg;
    m   = k;
    neg = 1'b0;
    if (2 * m > SINE_ENTRIES) begin
      neg = 1'b1;
      m   = SINE_ENTRIES - m;
    end
    xu = (longint'(PI_Q30) * 2 * longint'(m)) / SINE_ENTRIES;
    x  = longint'(xu);
    if (x > PI_Q30 / 2) x = PI_Q30 - x;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;   sum = sum - term;
    term = ((term * x2) >>> 30) / 20;  sum = sum + term;
    term = ((term * x2) >>> 30) / 42;  sum = sum - term;
    term = ((term * x2) >>> 30) / 72;  sum = sum + term;
    term = ((term * x2) >>> 30) / 110; sum = sum - term;
    term = ((term * x2) >>> 30) / 156; sum = sum + term;
    term = ((term * x2) >>> 30) / 210; sum = sum - term;
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    if (neg) sum = -sum;
    return 16'(sum);
  endfunction

  function automatic logic signed [SB-1:0] sat(input logic signed [OW-1:0] v);
    logic signed [OW-1:0] hi;
    logic signed [OW-1:0] lo;
    hi = OW'((longint'(1) <<< (SB - 1)) - 1);
    lo = -hi - OW'(1);
    if (v > hi) return SB'(hi);
    if (v < lo) return SB'(lo);
    return SB'(v);
  endfunction

  logic signed [15:0] sine_rom [SINE_ENTRIES];

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
    assign sine_rom[g] = sine_q15(g);
  end

  // ---------------------------------------------------------------- registers
  logic [PHASE_STEP_W-1:0] phase_step;
  logic [DELAY_REG_W-1:0]  base_delay;
  logic [DELAY_REG_W-1:0]  mod_span;
  logic [FB_W-1:0]         feedback_gain;
  logic [MIX_W-1:0]        wet_mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= PHASE_STEP_RST;
      base_delay    <= BASE_DELAY_RST;
      mod_span      <= MOD_SPAN_RST;
      feedback_gain <= FEEDBACK_RST;
      wet_mix       <= WET_MIX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP: phase_step <= cfg_wdata[PHASE_STEP_W-1:0];
        REG_BASE_DELAY: base_delay <= cfg_wdata[DELAY_REG_W-1:0];
        REG_MOD_SPAN:   mod_span   <= cfg_wdata[DELAY_REG_W-1:0];
        REG_FEEDBACK: begin
          feedback_gain <= (cfg_wdata[FB_W-1:0] > FB_MAX) ? FB_MAX : cfg_wdata[FB_W-1:0];
        end
        REG_WET_MIX: begin
          wet_mix <= (cfg_wdata[MIX_W-1:0] > MIX_MAX) ? MIX_MAX : cfg_wdata[MIX_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  state_t          state;
  logic [LFO_BITS-1:0] lfo_phase;
  logic [AW-1:0]   write_pointer;
  logic            full;

  logic            in_acc;
  logic            out_free;
  logic            ring_we;
  logic            rd_en;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign ring_we  = (state == ST_WRITE) && out_free;
  assign rd_en    = (state == ST_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      s_axis_tready <= 1'b0;
      m_axis_tvalid <= 1'b0;
      lfo_phase     <= '0;
      write_pointer <= '0;
      full          <= 1'b0;
    end else begin
      m_axis_tvalid <= ring_we || (m_axis_tvalid && !m_axis_tready);
      unique case (state)
        ST_IDLE: begin
          s_axis_tready <= !in_acc;
          if (in_acc) begin
            lfo_phase     <= lfo_phase + LFO_BITS'(phase_step);
            state         <= ST_SPAN;
          end
        end
        ST_SPAN:   state <= ST_ADDR;
        ST_ADDR:   state <= ST_READ;
        ST_READ:   state <= ST_INTERP;
        ST_INTERP: state <= ST_MULT;
        ST_MULT:   state <= ST_WRITE;
        ST_WRITE: begin
          if (out_free) begin
            if (write_pointer == AW'(DELAY_DEPTH - 1)) begin
              write_pointer <= '0;
              full          <= 1'b1;
            end else begin
              write_pointer <= write_pointer + AW'(1);
            end
            s_axis_tready <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [SB-1:0]  in_l, in_r;
  logic [IXW-1:0]        sine_idx;
  logic [35:0]           span_prod;
  logic [AW-1:0]         addr_a, addr_b;
  logic [7:0]            frac;
  logic                  ok_a, ok_b;
  logic                  vld_a, vld_b;
  logic signed [ISW-1:0] isum_l, isum_r;
  logic signed [FPW-1:0] fbp_l, fbp_r;
  logic signed [OPW-1:0] dry_l, dry_r, wet_l, wet_r;
  logic signed [SB-1:0]  wr_l, wr_r;
  logic signed [SB-1:0]  out_l, out_r;

  logic [PPW-1:0]        phase_prod;
  logic [DW-1:0]         delay_raw, delay_c;
  logic [AW:0]           tap_i, diff_a, diff_b;
  logic [AW-1:0]         nxt_a, nxt_b;
  logic [16:0]           dry_w;
  logic signed [SB-1:0]  rda_l, rdb_l, rda_r, rdb_r;
  logic signed [SB-1:0]  dl_l, dl_r;
  logic signed [OW-1:0]  fbs_l, fbs_r, os_l, os_r;

  assign phase_prod = PPW'(lfo_phase) * PPW'(SINE_ENTRIES);
  assign delay_raw  = DW'(base_delay) + DW'(span_prod[35:16]);

  always_comb begin
    delay_c = delay_raw;
    if (32'(delay_raw) > 32'(DMAX)) delay_c = DW'(DMAX);
    if (delay_c < DW'(256)) delay_c = DW'(256);
    tap_i  = (AW + 1)'(delay_c >> 8);
    diff_a = {1'b0, write_pointer} - tap_i;
    diff_b = diff_a - (AW + 1)'(1);
    nxt_a  = diff_a[AW] ? AW'(diff_a + (AW + 1)'(DELAY_DEPTH)) : diff_a[AW-1:0];
    nxt_b  = diff_b[AW] ? AW'(diff_b + (AW + 1)'(DELAY_DEPTH)) : diff_b[AW-1:0];
  end

  assign dry_w = 17'(MIX_MAX - wet_mix);
  assign dl_l  = SB'(isum_l >>> 8);
  assign dl_r  = SB'(isum_r >>> 8);

  assign fbs_l = OW'((fbp_l + FPW'(32768)) >>> 16) + OW'(in_l);
  assign fbs_r = OW'((fbp_r + FPW'(32768)) >>> 16) + OW'(in_r);
  assign os_l  = (OW'(dry_l) + OW'(wet_l) + OW'(32768)) >>> 16;
  assign os_r  = (OW'(dry_r) + OW'(wet_r) + OW'(32768)) >>> 16;
  assign wr_l  = sat(fbs_l);
  assign wr_r  = sat(fbs_r);
  assign out_l = sat(os_l);
  assign out_r = sat(os_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_l     <= s_axis_tdata[SB-1:0];
      in_r     <= s_axis_tdata[2*SB-1:SB];
      sine_idx <= IXW'(phase_prod >> LFO_BITS);
    end
    if (state == ST_SPAN) begin
      span_prod <= 36'(mod_span) * 36'({~sine_rom[sine_idx][15], sine_rom[sine_idx][14:0]});
    end
    if (state == ST_ADDR) begin
      addr_a <= nxt_a;
      addr_b <= nxt_b;
      frac   <= delay_c[7:0];
      ok_a   <= full || (nxt_a < write_pointer);
      ok_b   <= full || (nxt_b < write_pointer);
    end
    if (state == ST_READ) begin
      vld_a <= ok_a;
      vld_b <= ok_b;
    end
    if (state == ST_INTERP) begin
      isum_l <= ISW'(rda_l * $signed({1'b0, 9'(256 - 9'(frac))}))
              + ISW'(rdb_l * $signed({1'b0, 9'(frac)})) + ISW'(128);
      isum_r <= ISW'(rda_r * $signed({1'b0, 9'(256 - 9'(frac))}))
              + ISW'(rdb_r * $signed({1'b0, 9'(frac)})) + ISW'(128);
    end
    if (state == ST_MULT) begin
      fbp_l <= FPW'(dl_l * $signed({1'b0, feedback_gain}));
      fbp_r <= FPW'(dl_r * $signed({1'b0, feedback_gain}));
      dry_l <= OPW'(in_l * $signed({1'b0, dry_w}));
      dry_r <= OPW'(in_r * $signed({1'b0, dry_w}));
      wet_l <= OPW'(dl_l * $signed({1'b0, wet_mix}));
      wet_r <= OPW'(dl_r * $signed({1'b0, wet_mix}));
    end
    if (ring_we) m_axis_tdata <= TDATA_W'({out_r, out_l});
  end

  // ---------------------------------------------------------------- rings
  logic signed [SB-1:0] left_ring  [DELAY_DEPTH];
  logic signed [SB-1:0] right_ring [DELAY_DEPTH];
  logic signed [SB-1:0] ra_l, rb_l, ra_r, rb_r;

  always_ff @(posedge clk) begin
    if (ring_we) left_ring[write_pointer] <= wr_l;
    if (rd_en) begin
      ra_l <= left_ring[addr_a];
      rb_l <= left_ring[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) right_ring[write_pointer] <= wr_r;
    if (rd_en) begin
      ra_r <= right_ring[addr_a];
      rb_r <= right_ring[addr_b];
    end
  end

  // unwritten entries read as zero
  assign rda_l = vld_a ? ra_l : '0;
  assign rdb_l = vld_b ? rb_l : '0;
  assign rda_r = vld_a ? ra_r : '0;
  assign rdb_r = vld_b ? rb_r : '0;

endmodule

@@ src/scd_checker.sv @@
// ----------------------------------------------------------------------------
// scd_checker - port-level checks for the stereo chorus delay
// Output hold under stall, reset behavior, one item in flight at a time.
// ----------------------------------------------------------------------------
module scd_checker #(
  parameter int TDATA_W = 48
) (
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("handshake not cleared by reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after an item was taken");

endmodule

bind stereo_chorus_delay scd_checker #(
  .TDATA_W(((2 * SAMPLE_BITS + 7) / 8) * 8)
) u_scd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/scd_checker.sv @@
// ----------------------------------------------------------------------------
// scd_scoreboard - frame predictor and scoreboard for stereo_chorus_delay
// Snoops the config port and both streams, keeps its own LFO, sine table,
// delay rings and registers, predicts each output frame as an input item is
// accepted, and compares accepted output items in order, field by field.
// ----------------------------------------------------------------------------
module scd_scoreboard #(
  parameter int DELAY_DEPTH  = scd_pkg::DEF_DELAY_DEPTH,
  parameter int SINE_ENTRIES = scd_pkg::DEF_SINE_ENTRIES,
  parameter int SW           = scd_pkg::DEF_SAMPLE_BITS,
  parameter int TDATA_W      = ((2 * SW + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [TDATA_W-1:0]             s_axis_tdata,   // left_in, right_in
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [TDATA_W-1:0]             m_axis_tdata,   // left_out, right_out
  input  logic                           cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    mismatches,
  output int unsigned                    frames_checked,
  output int unsigned                    outstanding
);
  import scd_pkg::*;

  typedef struct packed {
    logic signed [SW-1:0] right;
    logic signed [SW-1:0] left;
  } frame_t;

  localparam longint TAP_MAX = longint'(DELAY_DEPTH - 2) * 256;

  int                   sine_tab [SINE_ENTRIES];
  logic signed [SW-1:0] ring [2][DELAY_DEPTH];
  logic [LFO_BITS-1:0]  lfo_phase;
  int unsigned          wr_ptr;

  logic [PHASE_STEP_W-1:0] phase_step;
  logic [DELAY_REG_W-1:0]  base_delay;
  logic [DELAY_REG_W-1:0]  mod_span;
  logic [FB_W-1:0]         feedback_gain;
  logic [MIX_W-1:0]        wet_mix;

  frame_t expected_frames [$];

  // sin(2*pi*k/N) in Q1.15 via a Q2.30 Taylor series
  function automatic int sine_entry(input int k);
    longint x, x2, term, acc;
    int     m, n;
    bit     neg;
    m   = k % SINE_ENTRIES;
    neg = 1'b0;
    if (2 * m > SINE_ENTRIES) begin
      neg = 1'b1;
      m   = SINE_ENTRIES - m;
    end
    x = (PI_Q30 * 2 * longint'(m)) / SINE_ENTRIES;
    if (x > PI_Q30 / 2) x = PI_Q30 - x;
    x2   = (x * x) >>> 30;
    term = x;
    acc  = x;
    for (n = 1; n <= 7; n++) begin
      term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= term;
      else acc += term;
    end
    if (acc < 0) acc = 0;
    if (acc > ONE_Q30) acc = ONE_Q30;
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) acc = 32767;
    return neg ? -int'(acc) : int'(acc);
  endfunction

  initial begin
    for (int k = 0; k < SINE_ENTRIES; k++) sine_tab[k] = sine_entry(k);
  end

  function automatic logic signed [SW-1:0] saturate(input longint v);
    longint hi;
    hi = (longint'(1) << (SW - 1)) - 1;
    if (v > hi) return hi[SW-1:0];
    if (v < -hi - 1) return SW'(-hi - 1);
    return v[SW-1:0];
  endfunction

  // interpolated tap, ring write-back with feedback, dry/wet blend
  function automatic logic signed [SW-1:0] channel_out(input int ch, input longint x_in,
                                                       input longint dly);
    longint whole, frac, a, b, tap, fbv, blend;
    whole = dly >>> 8;
    frac  = dly & 255;
    a     = ring[ch][(longint'(wr_ptr) + DELAY_DEPTH - whole) % DELAY_DEPTH];
    b     = ring[ch][(longint'(wr_ptr) + DELAY_DEPTH - whole - 1) % DELAY_DEPTH];
    tap   = (a * (256 - frac) + b * frac + 128) >>> 8;
    fbv   = (tap * longint'(feedback_gain) + 32768) >>> 16;
    ring[ch][wr_ptr] = saturate(x_in + fbv);
    blend = (x_in * (65536 - longint'(wet_mix)) + tap * longint'(wet_mix) + 32768) >>> 16;
    return saturate(blend);
  endfunction

  function automatic frame_t chorus_frame(input frame_t din);
    longint idx, dly;
    int     s;
    frame_t res;
    idx = (longint'(lfo_phase) * SINE_ENTRIES) >>> LFO_BITS;
    if (idx >= SINE_ENTRIES) idx = SINE_ENTRIES - 1;
    s   = sine_tab[idx];
    lfo_phase = lfo_phase + phase_step;
    dly = longint'(base_delay) + ((longint'(mod_span) * longint'(s + 32768)) >>> 16);
    if (dly > TAP_MAX) dly = TAP_MAX;
    if (dly < 256) dly = 256;
    res.left  = channel_out(0, longint'(din.left), dly);
    res.right = channel_out(1, longint'(din.right), dly);
    wr_ptr = (wr_ptr + 1) % DELAY_DEPTH;
    return res;
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_t got, want;
    if (rst) begin
      lfo_phase     = '0;
      wr_ptr        = 0;
      phase_step    = PHASE_STEP_RST;
      base_delay    = BASE_DELAY_RST;
      mod_span      = MOD_SPAN_RST;
      feedback_gain = FEEDBACK_RST;
      wet_mix       = WET_MIX_RST;
      for (int k = 0; k < DELAY_DEPTH; k++) begin
        ring[0][k] = '0;
        ring[1][k] = '0;
      end
      expected_frames.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = frame_t'(m_axis_tdata[2*SW-1:0]);
        if (expected_frames.size() == 0) begin
          report($sformatf("output item %0d/%0d with no frame outstanding",
                           got.left, got.right));
        end else begin
          want = expected_frames.pop_front();
          if (got.left !== want.left)
            report($sformatf("frame %0d left_out expected %0d got %0d",
                             frames_checked, want.left, got.left));
          if (got.right !== want.right)
            report($sformatf("frame %0d right_out expected %0d got %0d",
                             frames_checked, want.right, got.right));
          frames_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_frames.push_back(chorus_frame(frame_t'(s_axis_tdata[2*SW-1:0])));
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_STEP: phase_step = cfg_wdata[PHASE_STEP_W-1:0];
          REG_BASE_DELAY: base_delay = cfg_wdata[DELAY_REG_W-1:0];
          REG_MOD_SPAN:   mod_span   = cfg_wdata[DELAY_REG_W-1:0];
          REG_FEEDBACK: begin
            feedback_gain = cfg_wdata[FB_W-1:0];
            if (feedback_gain > FB_MAX) feedback_gain = FB_MAX;
          end
          REG_WET_MIX: begin
            wet_mix = cfg_wdata[MIX_W-1:0];
            if (wet_mix > MIX_MAX) wet_mix = MIX_MAX;
          end
          default: ;
        endcase
      end
    end
    outstanding <= expected_frames.size();
  end

endmodule

@@ tb/tb_stereo_chorus_delay.sv @@
// ----------------------------------------------------------------------------
// tb_stereo_chorus_delay - stimulus and verdict for the stereo chorus delay
// Directed frames at sample extremes under clamped and extreme register
// settings, then random register settings with random frames, random gaps on
// both streams and long output hold-offs. Checking is done by scd_scoreboard.
// ----------------------------------------------------------------------------
module tb_stereo_chorus_delay;
  import scd_pkg::*;

  localparam int SW          = DEF_SAMPLE_BITS;
  localparam int TDATA_W     = ((2 * SW + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT     = 4_000_000;
  localparam int PHASE_ITEMS = 150;

  localparam logic [SW-1:0] SMP_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] SMP_MIN = {1'b1, {(SW - 1){1'b0}}};
  localparam logic [SW-1:0] SMP_A   = {(SW / 2){2'b10}};
  localparam logic [SW-1:0] SMP_5   = {(SW / 2){2'b01}};

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  int unsigned mismatches, frames_checked, outstanding;
  int unsigned settings_used = 0;
  int unsigned holds_done    = 0;
  int unsigned hold_left     = 0;
  int unsigned rx_gap        = 0;
  int unsigned rx_steady     = 0;
  bit          send_gaps     = 1'b1;
  bit          hold_req      = 1'b0;
  bit          hold_ack      = 1'b0;

  stereo_chorus_delay dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  scd_scoreboard u_scoreboard (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .frames_checked (frames_checked),
    .outstanding    (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #(TIMEOUT);
    $display("Verification failed");
    $finish;
  end

  // mostly short gaps, some medium, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return SW'($urandom_range(0, 8191) - 4096);
      default: return SW'($urandom);
    endcase
  endfunction

  // output side: random gaps, quiet stretches, and long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_ack      <= hold_req;
      holds_done    <= holds_done + 1;
    end else if (rx_gap != 0) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= rx_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_steady != 0) rx_steady <= rx_steady - 1;
      else if ($urandom_range(0, 99) < 3) rx_steady <= $urandom_range(20, 120);
      else if ($urandom_range(0, 99) < 35) rx_gap <= idle_len();
    end
  end

  task automatic send_frame(input logic [SW-1:0] left_s, input logic [SW-1:0] right_s);
    int unsigned gap;
    gap = (send_gaps && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right_s, left_s};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] ps, input logic [CFG_DATA_W-1:0] bd,
                                input logic [CFG_DATA_W-1:0] ms, input logic [CFG_DATA_W-1:0] fb,
                                input logic [CFG_DATA_W-1:0] wm);
    logic [CFG_IDX_W-1:0] junk_idx;
    junk_idx = CFG_IDX_W'($urandom_range(REG_WET_MIX + 1, (1 << CFG_IDX_W) - 1));
    drain();
    reg_write(junk_idx, CFG_DATA_W'($urandom));
    reg_write(REG_PHASE_STEP, ps);
    reg_write(REG_BASE_DELAY, bd);
    reg_write(REG_MOD_SPAN, ms);
    reg_write(REG_FEEDBACK, fb);
    reg_write(REG_WET_MIX, wm);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_settings(input int kind);
    case (kind)
      0: apply_settings(CFG_DATA_W'($urandom_range(0, 60000)),
                        CFG_DATA_W'($urandom_range(256, 40 * 256)),
                        CFG_DATA_W'($urandom_range(0, 20 * 256)),
                        CFG_DATA_W'($urandom_range(0, FB_MAX)),
                        CFG_DATA_W'($urandom_range(0, MIX_MAX)));
      1: apply_settings($urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0,
                        $urandom_range(0, 1) ? '1 : '0,
                        $urandom_range(0, 1) ? CFG_DATA_W'(FB_MAX) : '0,
                        $urandom_range(0, 1) ? CFG_DATA_W'(MIX_MAX) : '0);
      2: apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                        CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      default: apply_settings(CFG_DATA_W'($urandom_range(23'h100000, 23'h7FFFFF)),
                              CFG_DATA_W'($urandom_range(0, 3 * 256)),
                              CFG_DATA_W'($urandom_range(0, 16 * 256)),
                              CFG_DATA_W'($urandom_range(50000, 65535)),
                              CFG_DATA_W'($urandom_range(0, 131071)));
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values: long fixed delay, half wet, no feedback
    send_frame('0, '0);
    send_frame(SMP_MAX, SMP_MIN);
    send_frame(SMP_A, SMP_5);

    // delay under one sample, feedback and mix written above their limits
    apply_settings('0, '0, '0, 23'hFFFF, 23'h1FFFF);
    repeat (4) send_frame(SMP_MAX, SMP_MIN);
    repeat (2) send_frame(SMP_MIN, SMP_MAX);
    send_frame('0, '0);
    send_frame(1, '1);

    // delay past the ring end, fastest LFO, fully dry
    apply_settings('1, '1, '1, '0, '0);
    send_frame(SMP_MAX, SMP_MAX);
    send_frame(SMP_MIN, SMP_MIN);
    send_frame(SMP_5, SMP_A);
    send_frame('1, 1);

    // fractional delay with a swept tap
    apply_settings(23'h200000, 256 + 128, 8 * 256, 32768, 40000);
    repeat (2) send_frame(SMP_MAX, SMP_MIN);
    repeat (2) send_frame(SMP_MIN, SMP_MAX);
    repeat (4) send_frame(pick_sample(), pick_sample());

    for (int ph = 0; ph < 6; ph++) begin
      random_settings(ph % 4);
      send_gaps = ($urandom_range(0, 3) != 0);
      if (ph == 1 || ph == 4) begin
        send_gaps = 1'b0;
        hold_req <= ~hold_req;
      end
      repeat (PHASE_ITEMS) send_frame(pick_sample(), pick_sample());
    end

    drain();
    repeat (30) @(posedge clk);
    $display("Run covered %0d stereo frames under %0d register settings, clamps included.",
             frames_checked, settings_used);
    $display("Output held off %0d times for %0d cycles while input kept coming.",
             holds_done, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
